// File: sv/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// shared types and constants for the key debouncer with long-press detection
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int unsigned KeyW    = 8;
    localparam int unsigned HoldW   = 16;
    localparam int unsigned RelW    = 8;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDatW = 16;

    localparam logic [HoldW-1:0] PressConfirmReset = 16'd100;
    localparam logic [HoldW-1:0] LongPressReset    = 16'd6000;
    localparam logic [RelW-1:0]  ReleaseReset      = 8'd20;
    localparam logic [RelW-1:0]  RearmReset        = 8'd2;

    localparam logic [KeyW-1:0]  LongFlag = 8'h80;
    localparam logic [KeyW-1:0]  NoKey    = 8'h00;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PRESS_CONFIRM = 8'd0,
        REG_LONG_PRESS    = 8'd1,
        REG_RELEASE       = 8'd2,
        REG_REARM         = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CONFIRM = 3'd1,
        PH_HELD    = 3'd2,
        PH_REPORT  = 3'd3,
        PH_REARM   = 3'd4
    } phase_t;

endpackage

// File: sv/key_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_top
// scan-tick key debouncer reporting short and long presses
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one beat per scan tick, s_tdata holds the pressed-key mask
//   m_ channel: one beat for every input beat, m_tdata holds the key code
//     (zero for no key, else the captured mask, bit 7 set on a long press)
//   cfg channel: cfg_index selects the register (0 press confirm count,
//     1 long press count, 2 release count, 3 rearm count), cfg_data the
//     value; cfg_ready is always high, other indexes are dropped
// output: m_ carries the registered result in the cycle after its input beat
// throughput: one beat per cycle unless m_ stalls; the phase machine and both
//   counters update from the current state and the incoming sample
// stall: a single output register holds the result; while it is full and
//   m_tready is low, s_tready is low and the machine holds its state
// reset: aresetn (synchronous, low) returns the machine to idle, clears the
//   counters, empties the output register and loads the register defaults
// ----------------------------------------------------------------------------
module key_debounce_long_press_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: [7:0] keys_pressed
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kdlp_pkg::KeyW-1:0]         s_tdata,
    // tdata: [7:0] key_code
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kdlp_pkg::KeyW-1:0]         m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kdlp_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [kdlp_pkg::CfgDatW-1:0]      cfg_data
);

    localparam logic [kdlp_pkg::HoldW-1:0] HoldMax = '1;
    localparam logic [kdlp_pkg::RelW-1:0]  RelMax  = '1;

    logic [kdlp_pkg::HoldW-1:0] press_cfg_reg;
    logic [kdlp_pkg::HoldW-1:0] long_cfg_reg;
    logic [kdlp_pkg::RelW-1:0]  rel_cfg_reg;
    logic [kdlp_pkg::RelW-1:0]  rearm_cfg_reg;

    kdlp_pkg::phase_t           phase_reg, phase_next;
    logic [kdlp_pkg::KeyW-1:0]  captured_reg, captured_next;
    logic [kdlp_pkg::KeyW-1:0]  pending_reg, pending_next;
    logic [kdlp_pkg::HoldW-1:0] hold_reg, hold_next;
    logic [kdlp_pkg::RelW-1:0]  rel_reg, rel_next;

    logic                       out_valid_reg, out_valid_next;
    logic [kdlp_pkg::KeyW-1:0]  out_code_reg, out_code_next;

    logic                       in_beat;
    logic                       keys_same;
    logic                       keys_none;
    logic [kdlp_pkg::HoldW-1:0] hold_inc;
    logic [kdlp_pkg::RelW-1:0]  rel_inc;
    logic [kdlp_pkg::KeyW-1:0]  code;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_code_reg;

    assign keys_same = (s_tdata == captured_reg);
    assign keys_none = (s_tdata == kdlp_pkg::NoKey);
    // both counters saturate
    assign hold_inc  = (hold_reg == HoldMax) ? hold_reg : hold_reg + 1'b1;
    assign rel_inc   = (rel_reg == RelMax) ? rel_reg : rel_reg + 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_cfg_reg <= kdlp_pkg::PressConfirmReset;
            long_cfg_reg  <= kdlp_pkg::LongPressReset;
            rel_cfg_reg   <= kdlp_pkg::ReleaseReset;
            rearm_cfg_reg <= kdlp_pkg::RearmReset;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kdlp_pkg::REG_PRESS_CONFIRM: press_cfg_reg <= cfg_data;
                kdlp_pkg::REG_LONG_PRESS:    long_cfg_reg  <= cfg_data;
                kdlp_pkg::REG_RELEASE:       rel_cfg_reg   <= cfg_data[kdlp_pkg::RelW-1:0];
                kdlp_pkg::REG_REARM:         rearm_cfg_reg <= cfg_data[kdlp_pkg::RelW-1:0];
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            kdlp_pkg::PH_IDLE: begin
                if (!keys_none) phase_next = kdlp_pkg::PH_CONFIRM;
            end
            kdlp_pkg::PH_CONFIRM: begin
                if (!keys_same) begin
                    phase_next = kdlp_pkg::PH_IDLE;
                end else if (hold_inc > press_cfg_reg) begin
                    phase_next = kdlp_pkg::PH_HELD;
                end
            end
            kdlp_pkg::PH_HELD: begin
                if (keys_same) begin
                    if (hold_inc > long_cfg_reg) phase_next = kdlp_pkg::PH_REPORT;
                end else if (keys_none && (rel_inc > rel_cfg_reg)) begin
                    phase_next = kdlp_pkg::PH_REPORT;
                end
            end
            kdlp_pkg::PH_REPORT: phase_next = kdlp_pkg::PH_REARM;
            kdlp_pkg::PH_REARM: begin
                if (keys_none && (rel_inc > rearm_cfg_reg)) phase_next = kdlp_pkg::PH_IDLE;
            end
            default: phase_next = kdlp_pkg::PH_IDLE;
        endcase
    end

    // counters, captured pattern and reported code
    always_comb begin
        captured_next = captured_reg;
        pending_next  = pending_reg;
        hold_next     = hold_reg;
        rel_next      = rel_reg;
        code          = kdlp_pkg::NoKey;
        unique case (phase_reg)
            kdlp_pkg::PH_IDLE: begin
                if (!keys_none) begin
                    captured_next = s_tdata;
                    hold_next     = '0;
                    rel_next      = '0;
                end
            end
            kdlp_pkg::PH_CONFIRM: begin
                if (keys_same) begin
                    if (hold_inc > press_cfg_reg) begin
                        pending_next = captured_reg;
                        hold_next    = '0;
                    end else begin
                        hold_next    = hold_inc;
                    end
                end
            end
            kdlp_pkg::PH_HELD: begin
                if (keys_same) begin
                    if (hold_inc > long_cfg_reg) begin
                        pending_next = pending_reg | kdlp_pkg::LongFlag;
                        hold_next    = '0;
                    end else begin
                        hold_next    = hold_inc;
                    end
                end else if (keys_none) begin
                    rel_next = rel_inc;
                    if (rel_inc > rel_cfg_reg) pending_next = captured_reg;
                end
            end
            kdlp_pkg::PH_REPORT: code = pending_reg;
            kdlp_pkg::PH_REARM: begin
                if (keys_none) rel_next = rel_inc;
            end
            default: ;
        endcase
    end

    // output register: loads on an input beat, empties when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (in_beat) begin
            out_valid_next = 1'b1;
            out_code_next  = code;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= kdlp_pkg::PH_IDLE;
            captured_reg  <= kdlp_pkg::NoKey;
            pending_reg   <= kdlp_pkg::NoKey;
            hold_reg      <= '0;
            rel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                phase_reg    <= phase_next;
                captured_reg <= captured_next;
                pending_reg  <= pending_next;
                hold_reg     <= hold_next;
                rel_reg      <= rel_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_code_reg <= out_code_next;
    end

endmodule

// File: sv/kdlp_checker.sv
// ----------------------------------------------------------------------------
// kdlp_checker
// port-level checks for the key debouncer, bound to the top level
// ----------------------------------------------------------------------------
module kdlp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [kdlp_pkg::KeyW-1:0]    m_tdata
);

    // a held result beat keeps its code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every accepted sample yields a result beat next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted sample");

    // a stalled result blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // nothing pending straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind key_debounce_long_press_top kdlp_checker u_kdlp_checker (.*);

// File: tb/key_debounce_long_press_top_test.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_top_test
// self-checking bench for the scan-tick key debouncer with long-press report
// ----------------------------------------------------------------------------
// Every scan sample sent on the s_ stream is run through a cycle model of the
// debounce phase machine kept here, and the key code it gives is queued.
// Each m_ beat is checked against the oldest queued code. The run covers
// reset defaults, a directed walk through short, long and broken presses,
// the register extremes, release counter saturation, and random press
// episodes with noise under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module key_debounce_long_press_top_test;

    localparam int unsigned StallLimit = 1000;
    localparam int unsigned NumRegs    = 4;
    localparam int unsigned MaxShown   = 20;
    localparam int unsigned PhaseItems = 40;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [kdlp_pkg::KeyW-1:0]     s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [kdlp_pkg::KeyW-1:0]     m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [kdlp_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [kdlp_pkg::CfgDatW-1:0]  cfg_data  = '0;

    // debounce model state and its copy of the registers
    kdlp_pkg::phase_t              scan_st      = kdlp_pkg::PH_IDLE;
    logic [kdlp_pkg::KeyW-1:0]     held_keys    = kdlp_pkg::NoKey;
    logic [kdlp_pkg::KeyW-1:0]     code_pending = kdlp_pkg::NoKey;
    logic [kdlp_pkg::HoldW-1:0]    hold_cnt     = '0;
    logic [kdlp_pkg::RelW-1:0]     rel_cnt      = '0;
    logic [kdlp_pkg::HoldW-1:0]    cfg_confirm  = kdlp_pkg::PressConfirmReset;
    logic [kdlp_pkg::HoldW-1:0]    cfg_long     = kdlp_pkg::LongPressReset;
    logic [kdlp_pkg::RelW-1:0]     cfg_release  = kdlp_pkg::ReleaseReset;
    logic [kdlp_pkg::RelW-1:0]     cfg_rearm    = kdlp_pkg::RearmReset;

    logic [kdlp_pkg::KeyW-1:0]     key_codes_due[$];
    logic [kdlp_pkg::KeyW-1:0]     want_code;

    int unsigned         src_idle_pct   = 0;
    int unsigned         sink_stall_pct = 0;
    int unsigned         n_samples      = 0;
    int unsigned         n_checked      = 0;
    int unsigned         n_reports      = 0;
    int unsigned         n_errors       = 0;
    int unsigned         quiet_cycles   = 0;

    key_debounce_long_press_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one scan tick of the phase machine, returns the code it emits
    function automatic logic [kdlp_pkg::KeyW-1:0] next_key_code(
        input logic [kdlp_pkg::KeyW-1:0] keys);
        logic [kdlp_pkg::KeyW-1:0] code;
        code = kdlp_pkg::NoKey;
        case (scan_st)
            kdlp_pkg::PH_IDLE: begin
                if (keys != kdlp_pkg::NoKey) begin
                    held_keys = keys;
                    scan_st   = kdlp_pkg::PH_CONFIRM;
                    hold_cnt  = '0;
                    rel_cnt   = '0;
                end
            end
            kdlp_pkg::PH_CONFIRM: begin
                if (keys == held_keys) begin
                    if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt > cfg_confirm) begin
                        code_pending = held_keys;
                        hold_cnt     = '0;
                        scan_st      = kdlp_pkg::PH_HELD;
                    end
                end else begin
                    scan_st = kdlp_pkg::PH_IDLE;
                end
            end
            kdlp_pkg::PH_HELD: begin
                if (keys == held_keys) begin
                    if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt > cfg_long) begin
                        code_pending = code_pending | kdlp_pkg::LongFlag;
                        hold_cnt     = '0;
                        scan_st      = kdlp_pkg::PH_REPORT;
                    end
                end else if (keys == kdlp_pkg::NoKey) begin
                    if (rel_cnt != '1) rel_cnt = rel_cnt + 1'b1;
                    if (rel_cnt > cfg_release) begin
                        code_pending = held_keys;
                        scan_st      = kdlp_pkg::PH_REPORT;
                    end
                end
                // any other pattern is ignored while held
            end
            kdlp_pkg::PH_REPORT: begin
                code    = code_pending;
                scan_st = kdlp_pkg::PH_REARM;
            end
            kdlp_pkg::PH_REARM: begin
                // release count carries over from the held phase
                if (keys == kdlp_pkg::NoKey) begin
                    if (rel_cnt != '1) rel_cnt = rel_cnt + 1'b1;
                    if (rel_cnt > cfg_rearm) scan_st = kdlp_pkg::PH_IDLE;
                end
            end
            default: begin
                scan_st = kdlp_pkg::PH_IDLE;
            end
        endcase
        return code;
    endfunction

    // called just after a falling edge, returns just after the one past acceptance
    task automatic send_sample(input logic [kdlp_pkg::KeyW-1:0] keys);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= keys;
        do @(posedge aclk); while (!s_tready);
        key_codes_due.push_back(next_key_code(keys));
        n_samples++;
        @(negedge aclk);
    endtask

    task automatic wait_all_codes();
        s_tvalid <= 1'b0;
        while (key_codes_due.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [kdlp_pkg::CfgIdxW-1:0] idx,
                             input logic [kdlp_pkg::CfgDatW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            kdlp_pkg::REG_PRESS_CONFIRM: cfg_confirm = val;
            kdlp_pkg::REG_LONG_PRESS:    cfg_long    = val;
            kdlp_pkg::REG_RELEASE:       cfg_release = val[kdlp_pkg::RelW-1:0];
            kdlp_pkg::REG_REARM:         cfg_rearm   = val[kdlp_pkg::RelW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // needs small thresholds, or the held phase may never leave
    task automatic settle_idle();
        while (scan_st != kdlp_pkg::PH_IDLE) send_sample(kdlp_pkg::NoKey);
    endtask

    task automatic test_reset_defaults();
        repeat (int'(kdlp_pkg::PressConfirmReset) + 2) send_sample(8'h21);
        repeat (int'(kdlp_pkg::ReleaseReset) + int'(kdlp_pkg::RearmReset) + 4)
            send_sample(kdlp_pkg::NoKey);
        wait_all_codes();
    endtask

    task automatic test_directed_presses();
        localparam logic [kdlp_pkg::KeyW-1:0] Walk [25] = '{
            8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h7f, 8'h7f, 8'h7f, 8'h0f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
            8'h7f, 8'h7f, 8'h00, 8'h00, 8'h00, 8'hff, 8'h01, 8'hff,
            8'h00
        };
        cfg_write(kdlp_pkg::REG_PRESS_CONFIRM, 16'd1);
        cfg_write(kdlp_pkg::REG_LONG_PRESS, 16'd3);
        cfg_write(kdlp_pkg::REG_RELEASE, 16'd1);
        cfg_write(kdlp_pkg::REG_REARM, 16'd2);
        settle_idle();
        // bit 7 short press, long press with a stray pattern, broken confirms
        foreach (Walk[i]) send_sample(Walk[i]);
        wait_all_codes();
    endtask

    task automatic test_max_thresholds();
        cfg_write(kdlp_pkg::REG_PRESS_CONFIRM, 16'hffff);
        cfg_write(kdlp_pkg::REG_LONG_PRESS, 16'hffff);
        cfg_write(kdlp_pkg::REG_RELEASE, 16'hffff);
        cfg_write(kdlp_pkg::REG_REARM, 16'hffff);
        cfg_write(kdlp_pkg::CfgIdxW'($urandom_range(255, NumRegs)), 16'($urandom));
        cfg_write(kdlp_pkg::CfgIdxW'($urandom_range(255, NumRegs)), 16'($urandom));
        repeat (40) send_sample(8'ha5);
        send_sample(8'h5a);
        repeat (3) send_sample(kdlp_pkg::NoKey);
        wait_all_codes();
    endtask

    task automatic test_release_saturation();
        cfg_write(kdlp_pkg::REG_PRESS_CONFIRM, 16'd0);
        cfg_write(kdlp_pkg::REG_LONG_PRESS, 16'd2);
        cfg_write(kdlp_pkg::REG_RELEASE, 16'hff00 | 16'd255);
        cfg_write(kdlp_pkg::REG_REARM, 16'h3c00 | 16'd254);
        settle_idle();
        repeat (2) send_sample(8'h3c);
        // release count pins at its top, so no short report and instant rearm
        repeat (300) send_sample(kdlp_pkg::NoKey);
        repeat (4) send_sample(8'h3c);
        send_sample(kdlp_pkg::NoKey);
        repeat (6) send_sample(8'h3c);
        wait_all_codes();
    endtask

    task automatic press_episode();
        logic [kdlp_pkg::KeyW-1:0] pat;
        int unsigned               hold_len;
        int unsigned               gap_len;
        pat = kdlp_pkg::KeyW'($urandom_range(255, 1));
        if ($urandom_range(5) == 0) begin
            // plain noise
            repeat ($urandom_range(8, 1)) send_sample(kdlp_pkg::KeyW'($urandom));
        end else begin
            repeat ($urandom_range(2)) send_sample(kdlp_pkg::KeyW'($urandom));
            hold_len = $urandom_range(int'(cfg_confirm) + int'(cfg_long) + 4);
            for (int i = 0; i < hold_len; i++) begin
                if ($urandom_range(15) == 0)
                    send_sample($urandom_range(1) ? kdlp_pkg::NoKey
                                                  : kdlp_pkg::KeyW'($urandom));
                else
                    send_sample(pat);
            end
            gap_len = $urandom_range(int'(cfg_release) + int'(cfg_rearm) + 4);
            for (int i = 0; i < gap_len; i++) begin
                if ($urandom_range(15) == 0)
                    send_sample($urandom_range(1) ? pat : kdlp_pkg::KeyW'($urandom));
                else
                    send_sample(kdlp_pkg::NoKey);
            end
        end
        if ($urandom_range(9) == 0) wait_all_codes();
    endtask

    task automatic test_random_traffic(input int unsigned src_pct,
                                       input int unsigned sink_pct,
                                       input int unsigned max_thr);
        int unsigned stop_at;
        wait_all_codes();
        cfg_write(kdlp_pkg::REG_PRESS_CONFIRM, 16'($urandom_range(max_thr)));
        cfg_write(kdlp_pkg::REG_LONG_PRESS, 16'($urandom_range(3 * max_thr)));
        cfg_write(kdlp_pkg::REG_RELEASE, {8'($urandom), 8'($urandom_range(max_thr))});
        cfg_write(kdlp_pkg::REG_REARM, {8'($urandom), 8'($urandom_range(max_thr))});
        settle_idle();
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = n_samples + PhaseItems;
        while (n_samples < stop_at) press_episode();
        wait_all_codes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (key_codes_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MaxShown)
                    $display("%0t: key code with none expected, actual %02h", $time, m_tdata);
            end else begin
                want_code = key_codes_due.pop_front();
                n_checked++;
                if (want_code != kdlp_pkg::NoKey) n_reports++;
                if (m_tdata !== want_code) begin
                    n_errors++;
                    if (n_errors <= MaxShown)
                        $display("%0t: key code mismatch, expected %02h, actual %02h",
                                 $time, want_code, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_presses();
        test_max_thresholds();
        test_release_saturation();
        test_random_traffic(0, 0, 0);
        test_random_traffic(0, 0, 6);
        test_random_traffic(62, 0, 6);
        test_random_traffic(0, 62, 6);
        test_random_traffic(15, 15, 6);
        wait_all_codes();
        repeat (4) @(posedge aclk);
        if (key_codes_due.size() != 0) begin
            n_errors++;
            $display("%0t: %0d key codes never arrived", $time, key_codes_due.size());
        end
        $display("run covered %0d scan samples and %0d checked codes (%0d key reports)",
                 n_samples, n_checked, n_reports);
        $display("over reset defaults, register extremes, saturation and five stall mixes");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
